// ----- rtl/dsc_pkg.sv -----
// shared types and constants for the dictionary spell corrector
`timescale 1ns / 1ps

package dsc_pkg;

    localparam int CH_W    = 8;
    localparam int DIST_W  = 4;
    localparam int MAXD_W  = 3;
    localparam int COUNT_W = 32;

    // token handed from one cell to the next
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [CH_W-1:0]   ch;
        logic [CH_W-1:0]   prev_ch;
        logic [DIST_W-1:0] cap;
        logic [DIST_W-1:0] fresh;
        logic [DIST_W-1:0] rn_old;
        logic [DIST_W-1:0] rb_old;
        logic [DIST_W-1:0] rb_left;
        logic [CH_W-1:0]   q;
        logic [DIST_W-1:0] wdist;
    } t_link;

    // request from the top level to the best-word tracker
    typedef struct packed {
        logic               clear;
        logic               fire;
        logic [DIST_W-1:0]  wdist;
        logic [DIST_W-1:0]  cap;
        logic [COUNT_W-1:0] count;
    } t_best_req;

endpackage

// ----- rtl/dictionary_spell_corrector_core.sv -----
// top level of the dictionary spell corrector
`timescale 1ns / 1ps

// Query characters and dictionary characters are each taken at one per cycle
// while input is not stalled. Every dictionary character enters a chain of
// MAX_LEN cells, one per query position, and moves one cell per cycle, so the
// characters of a word flow back to back. The distance of a word leaves the
// end of the chain after the head register and every cell; input is stalled
// from the acceptance of its final character until then. Input is also
// stalled while a second result waits behind an untaken one.

module dictionary_spell_corrector_core #(
    parameter int MAX_LEN    = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dsc_pkg::MAXD_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_kind,
    input  logic [dsc_pkg::CH_W-1:0]     i_ch,
    input  logic                         i_last,
    input  logic [dsc_pkg::COUNT_W-1:0]  i_count,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [dsc_pkg::DIST_W-1:0]   o_word_distance,
    output logic [INDEX_BITS-1:0]        o_best_index,
    output logic [dsc_pkg::MAXD_W-1:0]   o_best_distance,
    output logic                         o_best_found,
    output logic                         o_corrected
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_LEN);
    localparam logic [5:0] DPOS_MAX = 6'd63;
    localparam logic [dsc_pkg::MAXD_W-1:0] MAXD_RST = 3'd2;

    logic [dsc_pkg::MAXD_W-1:0]  r_maxd;
    logic                        r_qopen;
    logic [LEN_W-1:0]            r_qlen;
    logic [5:0]                  r_dpos;
    logic [dsc_pkg::CH_W-1:0]    r_prev;
    logic [dsc_pkg::DIST_W-1:0]  r_rn0;
    logic [dsc_pkg::DIST_W-1:0]  r_rb0;
    logic [dsc_pkg::COUNT_W-1:0] r_cnt;
    logic                        r_inflight;
    dsc_pkg::t_link              r_head;
    dsc_pkg::t_link              n_head;

    logic                        r_out_v;
    logic [dsc_pkg::DIST_W-1:0]  r_out_wd;
    logic [INDEX_BITS-1:0]       r_out_bi;
    logic [dsc_pkg::MAXD_W-1:0]  r_out_bd;
    logic                        r_out_bf;
    logic                        r_out_co;
    logic                        r_skid_v;
    logic [dsc_pkg::DIST_W-1:0]  r_skid_wd;
    logic [INDEX_BITS-1:0]       r_skid_bi;
    logic [dsc_pkg::MAXD_W-1:0]  r_skid_bd;
    logic                        r_skid_bf;
    logic                        r_skid_co;

    logic                        acc;
    logic                        acc_q;
    logic                        acc_d;
    logic                        clear;
    logic [LEN_W-1:0]            q_base;
    logic                        q_room;
    logic                        q_we;
    logic [dsc_pkg::DIST_W-1:0]  cap;
    logic                        first;
    logic [6:0]                  j_pos;
    logic [dsc_pkg::DIST_W-1:0]  fresh0;
    logic [dsc_pkg::DIST_W-1:0]  rn0_o;
    logic [dsc_pkg::DIST_W-1:0]  rb0_o;
    logic                        tap;
    logic                        out_take;
    logic                        out_free;

    dsc_pkg::t_link              w_link [0:MAX_LEN];
    dsc_pkg::t_best_req          best_req;
    logic [dsc_pkg::DIST_W-1:0]  b_wd;
    logic [INDEX_BITS-1:0]       b_bi;
    logic [dsc_pkg::MAXD_W-1:0]  b_bd;
    logic                        b_bf;
    logic                        b_co;

    assign o_in_stall = r_inflight || r_skid_v;
    assign acc    = i_in_valid && !o_in_stall;
    assign acc_q  = acc && !i_kind;
    assign acc_d  = acc && i_kind;
    assign clear  = acc_q && !r_qopen;
    assign q_base = r_qopen ? r_qlen : '0;
    assign q_room = q_base < LEN_CAP;
    assign q_we   = acc_q && q_room;
    assign cap    = {1'b0, r_maxd} + 4'd1;

    always_comb begin
        first  = (r_dpos == '0);
        j_pos  = {1'b0, r_dpos} + 7'd1;
        fresh0 = (j_pos >= {3'd0, cap}) ? cap : j_pos[dsc_pkg::DIST_W-1:0];
        rn0_o  = first ? '0 : r_rn0;
        rb0_o  = first ? '0 : r_rb0;
        n_head         = '0;
        n_head.valid   = acc_d;
        n_head.first   = first;
        n_head.last    = i_last;
        n_head.ch      = i_ch;
        n_head.prev_ch = r_prev;
        n_head.cap     = cap;
        n_head.fresh   = fresh0;
        n_head.rn_old  = rn0_o;
        n_head.rb_old  = rb0_o;
        n_head.wdist   = (r_qlen == '0) ? fresh0 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxd     <= MAXD_RST;
            r_qopen    <= 1'b0;
            r_qlen     <= '0;
            r_dpos     <= '0;
            r_prev     <= '0;
            r_inflight <= 1'b0;
            r_head     <= '0;
        end else begin
            r_head <= n_head;
            if (i_cfg_we) begin
                r_maxd <= i_cfg_wdata;
            end
            if (acc_q) begin
                r_qopen <= !i_last;
                r_qlen  <= q_room ? q_base + 1'b1 : q_base;
            end else if (acc_d) begin
                r_qopen <= 1'b0;
            end
            if (clear) begin
                r_dpos <= '0;
                r_prev <= '0;
            end else if (acc_d) begin
                r_dpos <= i_last ? '0 : ((r_dpos == DPOS_MAX) ? DPOS_MAX : r_dpos + 1'b1);
                r_prev <= i_last ? '0 : i_ch;
            end
            if (acc_d && i_last) begin
                r_inflight <= 1'b1;
            end else if (tap) begin
                r_inflight <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_d) begin
            r_rn0 <= fresh0;
            r_rb0 <= rn0_o;
        end
        if (acc_d && i_last) begin
            r_cnt <= i_count;
        end
    end

    assign w_link[0] = r_head;

    for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
        dsc_cell #(
            .K     (k),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_q_we   (q_we),
            .i_q_idx  (q_base),
            .i_q_char (i_ch),
            .i_qlen   (r_qlen),
            .i_link   (w_link[k-1]),
            .o_link   (w_link[k])
        );
    end

    assign tap = w_link[MAX_LEN].valid && w_link[MAX_LEN].last;

    always_comb begin
        best_req.clear = clear;
        best_req.fire  = tap;
        best_req.wdist = w_link[MAX_LEN].wdist;
        best_req.cap   = w_link[MAX_LEN].cap;
        best_req.count = r_cnt;
    end

    dsc_best #(
        .INDEX_BITS (INDEX_BITS)
    ) u_best (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (best_req),
        .o_word_distance (b_wd),
        .o_best_index    (b_bi),
        .o_best_distance (b_bd),
        .o_best_found    (b_bf),
        .o_corrected     (b_co)
    );

    assign out_take = r_out_v && !i_out_stall;
    assign out_free = !r_out_v || out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (tap) begin
                if (out_free) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (r_skid_v && out_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else if (out_take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tap && out_free) begin
            r_out_wd <= b_wd;
            r_out_bi <= b_bi;
            r_out_bd <= b_bd;
            r_out_bf <= b_bf;
            r_out_co <= b_co;
        end else if (!tap && r_skid_v && out_free) begin
            r_out_wd <= r_skid_wd;
            r_out_bi <= r_skid_bi;
            r_out_bd <= r_skid_bd;
            r_out_bf <= r_skid_bf;
            r_out_co <= r_skid_co;
        end
        if (tap && !out_free) begin
            r_skid_wd <= b_wd;
            r_skid_bi <= b_bi;
            r_skid_bd <= b_bd;
            r_skid_bf <= b_bf;
            r_skid_co <= b_co;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_word_distance = r_out_wd;
    assign o_best_index    = r_out_bi;
    assign o_best_distance = r_out_bd;
    assign o_best_found    = r_out_bf;
    assign o_corrected     = r_out_co;

endmodule

// ----- rtl/dsc_cell.sv -----
// one alignment cell: holds one query character and its column of the distance rows
`timescale 1ns / 1ps

module dsc_cell #(
    parameter int K     = 1,
    parameter int LEN_W = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_we,
    input  logic [LEN_W-1:0]         i_q_idx,
    input  logic [dsc_pkg::CH_W-1:0] i_q_char,
    input  logic [LEN_W-1:0]         i_qlen,
    input  dsc_pkg::t_link           i_link,
    output dsc_pkg::t_link           o_link
);

    localparam int                       K_SAT  = (K > 15) ? 15 : K;
    localparam logic [dsc_pkg::DIST_W-1:0] K_INIT = dsc_pkg::DIST_W'(K_SAT);
    localparam logic [LEN_W-1:0]         IDX    = LEN_W'(K - 1);
    localparam logic [LEN_W-1:0]         POS    = LEN_W'(K);
    localparam bit                       TR_OK  = (K >= 2);

    logic [dsc_pkg::CH_W-1:0]   r_q;
    logic [dsc_pkg::DIST_W-1:0] r_rn;
    logic [dsc_pkg::DIST_W-1:0] r_rb;
    dsc_pkg::t_link             r_link;
    dsc_pkg::t_link             n_link;

    logic [dsc_pkg::DIST_W-1:0] init_v;
    logic [dsc_pkg::DIST_W-1:0] rn_o;
    logic [dsc_pkg::DIST_W-1:0] rb_o;
    logic [dsc_pkg::DIST_W:0]   c_up;
    logic [dsc_pkg::DIST_W:0]   c_left;
    logic [dsc_pkg::DIST_W:0]   c_diag;
    logic [dsc_pkg::DIST_W:0]   c_tr;
    logic [dsc_pkg::DIST_W:0]   v0;
    logic [dsc_pkg::DIST_W:0]   v1;
    logic [dsc_pkg::DIST_W:0]   v2;
    logic                       trans;
    logic [dsc_pkg::DIST_W-1:0] fresh;

    always_comb begin
        init_v = (K_INIT < i_link.cap) ? K_INIT : i_link.cap;
        rn_o   = i_link.first ? init_v : r_rn;
        rb_o   = i_link.first ? init_v : r_rb;
        c_up   = {1'b0, rn_o} + 5'd1;
        c_left = {1'b0, i_link.fresh} + 5'd1;
        c_diag = {1'b0, i_link.rn_old} + {4'd0, (r_q != i_link.ch)};
        c_tr   = {1'b0, i_link.rb_left} + 5'd1;
        trans  = TR_OK && !i_link.first && (r_q == i_link.prev_ch) && (i_link.q == i_link.ch);
        v0     = (c_left < c_up) ? c_left : c_up;
        v1     = (c_diag < v0) ? c_diag : v0;
        v2     = (trans && (c_tr < v1)) ? c_tr : v1;
        fresh  = (v2 < {1'b0, i_link.cap}) ? v2[dsc_pkg::DIST_W-1:0] : i_link.cap;
    end

    always_comb begin
        n_link         = i_link;
        n_link.fresh   = fresh;
        n_link.rn_old  = rn_o;
        n_link.rb_old  = rb_o;
        n_link.rb_left = i_link.rb_old;
        n_link.q       = r_q;
        n_link.wdist   = (i_qlen == POS) ? fresh : i_link.wdist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_we && (i_q_idx == IDX)) begin
            r_q <= i_q_char;
        end
        if (i_link.valid) begin
            r_rn <= fresh;
            r_rb <= rn_o;
        end
    end

    assign o_link = r_link;

endmodule

// ----- rtl/dsc_best.sv -----
// best-word tracker: keeps the closest, most frequent dictionary word
`timescale 1ns / 1ps

module dsc_best #(
    parameter int INDEX_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dsc_pkg::t_best_req          i_req,
    output logic [dsc_pkg::DIST_W-1:0]  o_word_distance,
    output logic [INDEX_BITS-1:0]       o_best_index,
    output logic [dsc_pkg::MAXD_W-1:0]  o_best_distance,
    output logic                        o_best_found,
    output logic                        o_corrected
);

    logic                        r_valid;
    logic [INDEX_BITS-1:0]       r_entry;
    logic [dsc_pkg::MAXD_W-1:0]  r_dist;
    logic [dsc_pkg::COUNT_W-1:0] r_freq;
    logic [INDEX_BITS-1:0]       r_wc;

    logic                        n_valid;
    logic [INDEX_BITS-1:0]       n_entry;
    logic [dsc_pkg::MAXD_W-1:0]  n_dist;
    logic [dsc_pkg::COUNT_W-1:0] n_freq;
    logic [INDEX_BITS-1:0]       n_wc;

    logic cand;
    logic better;

    always_comb begin
        cand   = i_req.wdist < i_req.cap;
        better = !r_valid || (i_req.wdist < {1'b0, r_dist})
                 || ((i_req.wdist == {1'b0, r_dist}) && (i_req.count > r_freq));
        n_valid = r_valid;
        n_entry = r_entry;
        n_dist  = r_dist;
        n_freq  = r_freq;
        n_wc    = r_wc;
        if (i_req.clear) begin
            n_valid = 1'b0;
            n_entry = '0;
            n_dist  = '0;
            n_freq  = '0;
            n_wc    = '0;
        end else if (i_req.fire) begin
            if (cand && better) begin
                n_valid = 1'b1;
                n_entry = r_wc;
                n_dist  = i_req.wdist[dsc_pkg::MAXD_W-1:0];
                n_freq  = i_req.count;
            end
            n_wc = r_wc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_entry <= '0;
            r_dist  <= '0;
            r_freq  <= '0;
            r_wc    <= '0;
        end else begin
            r_valid <= n_valid;
            r_entry <= n_entry;
            r_dist  <= n_dist;
            r_freq  <= n_freq;
            r_wc    <= n_wc;
        end
    end

    assign o_word_distance = i_req.wdist;
    assign o_best_index    = n_valid ? n_entry : '0;
    assign o_best_distance = n_valid ? n_dist : '0;
    assign o_best_found    = n_valid;
    assign o_corrected     = n_valid && (n_dist != '0);

endmodule

// ----- rtl/dsc_check.sv -----
// port-level checker for the dictionary spell corrector, bound to the top level
`timescale 1ns / 1ps

module dsc_check #(
    parameter int INDEX_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_kind,
    input logic [dsc_pkg::CH_W-1:0]     i_ch,
    input logic                         i_last,
    input logic [dsc_pkg::COUNT_W-1:0]  i_count,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [dsc_pkg::DIST_W-1:0]   o_word_distance,
    input logic [INDEX_BITS-1:0]        o_best_index,
    input logic [dsc_pkg::MAXD_W-1:0]   o_best_distance,
    input logic                         o_best_found,
    input logic                         o_corrected
);

    // no best word means the best fields read as zero
    a_empty_best : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_best_found) |-> (o_best_index == '0 && o_best_distance == '0))
        else $error("best fields not zero without a best word");

    // corrected only with a found best word at nonzero distance
    a_corrected : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_corrected) |-> (o_best_found && o_best_distance != '0))
        else $error("corrected without a nonzero best distance");

    // a stalled input transaction holds its payload
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_kind) && $stable(i_ch)
            && $stable(i_last) && $stable(i_count)))
        else $error("stalled input transaction changed");

    // a stalled result transaction holds its payload
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_word_distance)
            && $stable(o_best_index) && $stable(o_best_distance)
            && $stable(o_best_found) && $stable(o_corrected)))
        else $error("stalled result transaction changed");

endmodule

bind dictionary_spell_corrector_core dsc_check #(.INDEX_BITS(INDEX_BITS)) u_dsc_check (.*);

// ----- bench/tb_dictionary_spell_corrector_core.sv -----
// testbench for the dictionary spell corrector core with a self-checking scoreboard
`timescale 1ns / 1ps

module tb_dictionary_spell_corrector_core;

    localparam int QMAX      = 32;
    localparam int IDX_W     = 16;
    localparam int LIMIT     = 400000;
    localparam int SETTLE    = QMAX + 8;
    localparam int PHASE_LEN = 200;

    typedef struct packed {
        logic [dsc_pkg::DIST_W-1:0] word_distance;
        logic [IDX_W-1:0]           best_index;
        logic [dsc_pkg::MAXD_W-1:0] best_distance;
        logic                       best_found;
        logic                       corrected;
    } t_spell_result;

    typedef enum int {EDIT_SUB, EDIT_INS, EDIT_DEL, EDIT_SWAP} t_edit_kind;

    class spell_scoreboard;
        logic [7:0]       query_mem [QMAX];
        int               query_len;
        bit               query_loading;
        int               row_now    [QMAX+1];
        int               row_before [QMAX+1];
        logic [7:0]       prev_ch;
        int               dict_pos;
        logic [IDX_W-1:0] word_cnt;
        logic [IDX_W-1:0] best_idx;
        int               best_dist;
        logic [31:0]      best_cnt;
        bit               best_ok;
        int               max_dist;
        t_spell_result    expected [$];
        int               errors;

        function new();
            foreach (query_mem[k]) query_mem[k] = 8'h00;
            query_len     = 0;
            query_loading = 1'b0;
            max_dist      = 2;
            errors        = 0;
            restart();
        endfunction

        function void fill_rows();
            int cap;
            cap = max_dist + 1;
            for (int k = 0; k <= QMAX; k++) begin
                row_now[k]    = (k < cap) ? k : cap;
                row_before[k] = row_now[k];
            end
        endfunction

        function void restart();
            word_cnt  = '0;
            best_idx  = '0;
            best_dist = 0;
            best_cnt  = '0;
            best_ok   = 1'b0;
            dict_pos  = 0;
            prev_ch   = 8'h00;
            fill_rows();
        endfunction

        function void note_input(bit kind, logic [7:0] ch, bit last, logic [31:0] count);
            int            cap;
            int            j;
            int            v;
            int            d;
            int            fresh [QMAX+1];
            t_spell_result r;
            if (!kind) begin
                if (!query_loading) begin
                    query_loading = 1'b1;
                    query_len     = 0;
                    restart();
                end
                if (query_len < QMAX) begin
                    query_mem[query_len] = ch;
                    query_len++;
                end
                if (last) query_loading = 1'b0;
                return;
            end
            query_loading = 1'b0;
            if (dict_pos == 0) fill_rows();
            cap      = max_dist + 1;
            j        = dict_pos + 1;
            fresh[0] = (j < cap) ? j : cap;
            for (int k = 1; k <= query_len; k++) begin
                v = row_now[k] + 1;
                if (fresh[k-1] + 1 < v) v = fresh[k-1] + 1;
                if (row_now[k-1] + ((query_mem[k-1] != ch) ? 1 : 0) < v)
                    v = row_now[k-1] + ((query_mem[k-1] != ch) ? 1 : 0);
                if (k >= 2 && j >= 2 && query_mem[k-1] == prev_ch && query_mem[k-2] == ch &&
                    row_before[k-2] + 1 < v)
                    v = row_before[k-2] + 1;
                fresh[k] = (v < cap) ? v : cap;
            end
            for (int k = 0; k <= query_len; k++) begin
                row_before[k] = row_now[k];
                row_now[k]    = fresh[k];
            end
            prev_ch  = ch;
            dict_pos = (j < 63) ? j : 63;
            if (!last) return;
            d = row_now[query_len];
            if (d <= max_dist &&
                (!best_ok || d < best_dist || (d == best_dist && count > best_cnt))) begin
                best_ok   = 1'b1;
                best_idx  = word_cnt;
                best_dist = d;
                best_cnt  = count;
            end
            r.word_distance = dsc_pkg::DIST_W'(d);
            r.best_index    = best_ok ? best_idx : '0;
            r.best_distance = best_ok ? dsc_pkg::MAXD_W'(best_dist) : '0;
            r.best_found    = best_ok;
            r.corrected     = best_ok && best_dist >= 1;
            expected.push_back(r);
            word_cnt = word_cnt + 1'b1;
            dict_pos = 0;
            prev_ch  = 8'h00;
        endfunction

        function void check_result(t_spell_result got);
            t_spell_result exp;
            if (expected.size() == 0) begin
                $error("unexpected result transaction: word_distance %0d best_index %0d",
                       got.word_distance, got.best_index);
                errors++;
                return;
            end
            exp = expected.pop_front();
            if (got.word_distance !== exp.word_distance) begin
                $error("word_distance: expected %0d, got %0d", exp.word_distance,
                       got.word_distance);
                errors++;
            end
            if (got.best_index !== exp.best_index) begin
                $error("best_index: expected %0d, got %0d", exp.best_index, got.best_index);
                errors++;
            end
            if (got.best_distance !== exp.best_distance) begin
                $error("best_distance: expected %0d, got %0d", exp.best_distance,
                       got.best_distance);
                errors++;
            end
            if (got.best_found !== exp.best_found) begin
                $error("best_found: expected %0d, got %0d", exp.best_found, got.best_found);
                errors++;
            end
            if (got.corrected !== exp.corrected) begin
                $error("corrected: expected %0d, got %0d", exp.corrected, got.corrected);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [dsc_pkg::MAXD_W-1:0]  i_cfg_wdata;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_kind;
    logic [dsc_pkg::CH_W-1:0]    i_ch;
    logic                        i_last;
    logic [dsc_pkg::COUNT_W-1:0] i_count;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [dsc_pkg::DIST_W-1:0]  o_word_distance;
    logic [IDX_W-1:0]            o_best_index;
    logic [dsc_pkg::MAXD_W-1:0]  o_best_distance;
    logic                        o_best_found;
    logic                        o_corrected;

    spell_scoreboard sb;
    t_spell_result   seen;
    logic [7:0]      word_buf  [$];
    logic [7:0]      query_buf [$];
    int              n_items;
    int              cycles;
    int              send_idle_pct;
    int              recv_idle_pct;

    dictionary_spell_corrector_core #(
        .MAX_LEN    (QMAX),
        .INDEX_BITS (IDX_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_ch            (i_ch),
        .i_last          (i_last),
        .i_count         (i_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_word_distance (o_word_distance),
        .o_best_index    (o_best_index),
        .o_best_distance (o_best_distance),
        .o_best_found    (o_best_found),
        .o_corrected     (o_corrected)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_input(i_kind, i_ch, i_last, i_count);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.word_distance = o_word_distance;
            seen.best_index    = o_best_index;
            seen.best_distance = o_best_distance;
            seen.best_found    = o_best_found;
            seen.corrected     = o_corrected;
            sb.check_result(seen);
        end
    end

    task automatic send_item(input bit kind, input logic [7:0] ch, input bit last,
                             input logic [31:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_ch       <= ch;
        i_last     <= last;
        i_count    <= count;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_items++;
    endtask

    task automatic send_buf(input bit kind, input bit with_last, input logic [31:0] count);
        int n;
        n = word_buf.size();
        for (int k = 0; k < n; k++) begin
            if (with_last && k == n - 1)
                send_item(kind, word_buf[k], 1'b1, count);
            else
                send_item(kind, word_buf[k], 1'b0, $urandom);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected.size() != 0);
    endtask

    task automatic set_max_distance(input int value);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dsc_pkg::MAXD_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.max_dist = value;
    endtask

    function automatic logic [7:0] rand_char(bit narrow);
        if (narrow) return 8'h61 + 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [31:0] rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 30) return $urandom_range(3);
        if (r < 40) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic fill_random(input int lo, input int hi, input bit narrow);
        int n;
        n = $urandom_range(hi, lo);
        word_buf.delete();
        repeat (n) word_buf.push_back(rand_char(narrow));
    endtask

    task automatic build_variant(input bit narrow);
        int         edits;
        int         pos;
        t_edit_kind op;
        logic [7:0] t;
        word_buf = query_buf;
        edits    = $urandom_range(4);
        repeat (edits) begin
            op  = t_edit_kind'($urandom_range(3));
            pos = (word_buf.size() == 0) ? 0 : $urandom_range(word_buf.size() - 1);
            unique case (op)
                EDIT_SUB: begin
                    if (word_buf.size() > 0) word_buf[pos] = rand_char(narrow);
                end
                EDIT_INS: begin
                    word_buf.insert(pos, rand_char(narrow));
                end
                EDIT_DEL: begin
                    if (word_buf.size() > 1) word_buf.delete(pos);
                end
                EDIT_SWAP: begin
                    if (pos + 1 < word_buf.size()) begin
                        t = word_buf[pos];
                        word_buf[pos] = word_buf[pos+1];
                        word_buf[pos+1] = t;
                    end
                end
            endcase
        end
        if (word_buf.size() == 0) word_buf.push_back(rand_char(narrow));
    endtask

    task automatic random_sequence();
        int r;
        int n;
        bit narrow;
        narrow = ($urandom_range(3) != 0);
        r = $urandom_range(99);
        if (r < 85) begin
            n = $urandom_range(99);
            if (n < 3)
                fill_random(QMAX + 1, QMAX + 8, narrow);
            else if (n < 15)
                fill_random(9, QMAX, narrow);
            else
                fill_random(1, 8, narrow);
            query_buf = word_buf;
            send_buf(1'b0, 1'b1, $urandom);
            n = $urandom_range(6, 1);
            repeat (n) begin
                r = $urandom_range(99);
                if (r < 2)
                    fill_random(60, 70, narrow);
                else if (r < 12)
                    fill_random(1, 10, narrow);
                else
                    build_variant(narrow);
                send_buf(1'b1, 1'b1, rand_count());
            end
        end else if (r < 90) begin
            // query left open, then closed by a dictionary word
            fill_random(1, 4, narrow);
            query_buf = word_buf;
            send_buf(1'b0, 1'b0, $urandom);
            build_variant(narrow);
            send_buf(1'b1, 1'b1, rand_count());
        end else if (r < 95) begin
            fill_random(1, 4, narrow);
            send_buf(1'b1, 1'b0, $urandom);
        end else begin
            fill_random(1, 10, narrow);
            send_buf(1'b1, 1'b1, rand_count());
        end
    endtask

    task automatic run_phase(input int cfg, input int s_idle, input int r_idle);
        int stop;
        bit paused;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        // word in flight across the register write
        word_buf = '{8'h61, 8'h62};
        send_buf(1'b1, 1'b0, $urandom);
        set_max_distance(cfg);
        word_buf = '{8'h63};
        send_buf(1'b1, 1'b1, rand_count());
        stop   = n_items + PHASE_LEN;
        paused = 1'b0;
        while (n_items < stop) begin
            random_sequence();
            if (!paused && n_items >= stop - PHASE_LEN / 2) begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    task automatic run_directed();
        // dictionary word against an empty query
        word_buf = '{8'h61, 8'h62};
        send_buf(1'b1, 1'b1, 32'd5);
        word_buf = '{8'h63, 8'h61, 8'h74};
        send_buf(1'b0, 1'b1, 32'd0);
        send_buf(1'b1, 1'b1, 32'd0);
        word_buf = '{8'h61, 8'h63, 8'h74};
        send_buf(1'b1, 1'b1, 32'hFFFF_FFFF);
        word_buf = '{8'h63, 8'h61};
        send_buf(1'b1, 1'b1, 32'd7);
        // query closed by a dictionary character
        word_buf = '{8'h78};
        send_buf(1'b0, 1'b0, 32'd0);
        word_buf = '{8'h78, 8'h78};
        send_buf(1'b1, 1'b1, 32'd3);
        // new query inside a dictionary word
        send_item(1'b1, 8'h71, 1'b0, 32'd0);
        send_item(1'b0, 8'h7A, 1'b1, 32'd0);
        send_item(1'b1, 8'h7A, 1'b1, 32'd1);
        word_buf = '{8'h00, 8'hFF};
        send_buf(1'b0, 1'b1, 32'hFFFF_FFFF);
        word_buf = '{8'hFF, 8'h00};
        send_buf(1'b1, 1'b1, 32'hFFFF_FFFF);
        word_buf = '{8'h00, 8'hFF};
        send_buf(1'b1, 1'b1, 32'hFFFF_FFFF);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_kind        = 1'b0;
        i_ch          = '0;
        i_last        = 1'b0;
        i_count       = '0;
        i_out_stall   = 1'b0;
        n_items       = 0;
        cycles        = 0;
        send_idle_pct = 11;
        recv_idle_pct = 56;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_phase(0, 11, 56);
        run_phase(7, 11, 56);
        run_phase(3, 56, 11);
        run_phase(1, 56, 11);
        run_phase(7, 0, 0);
        run_phase(5, 0, 0);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
